FILE: src/nii_pkg.sv
// shared types, constants and helpers of the nd index iterator
package nii_pkg;

  localparam int NUM_CELLS   = 4;
  localparam int MAX_DIMS    = 4;
  localparam int EXTENT_BITS = 12;
  localparam int POS_W       = 13;
  localparam int FLAT_W      = 49;
  localparam int CFG_W       = 13;
  localparam int CFG_IDX_W   = 3;
  localparam int DIM_W       = 3;

  localparam int DIM_CAP = (MAX_DIMS < NUM_CELLS) ? MAX_DIMS : NUM_CELLS;
  localparam logic [POS_W-1:0] EXT_TOP = POS_W'(1) << EXTENT_BITS;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_0 = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    REQ_STEP   = 2'd0,
    REQ_LOAD   = 2'd1,
    REQ_REWIND = 2'd2
  } req_e;

  typedef enum logic [1:0] {
    LD_OK       = 2'd0,
    LD_NEG_FAR  = 2'd1,
    LD_TOO_BIG  = 2'd2
  } ld_status_e;

  typedef struct packed {
    logic apply;
    req_e req;
    logic used;
    logic set_end;
    logic load_ok;
  } cell_ctrl_t;

  typedef struct packed {
    logic              vld;
    logic              out;
    logic [FLAT_W-1:0] acc;
  } flat_t;

  typedef struct packed {
    logic [NUM_CELLS-1:0][POS_W-1:0] pos;
    logic [FLAT_W-1:0]               flat;
    logic                            is_out;
    ld_status_e                      status;
  } res_t;

  function automatic logic [POS_W-1:0] eff_extent(input logic [POS_W-1:0] e);
    logic [POS_W-1:0] r;
    r = e;
    if (r == '0) r = POS_W'(1);
    if (r > EXT_TOP) r = EXT_TOP;
    return r;
  endfunction

  function automatic logic [DIM_W-1:0] used_dims(input logic [DIM_W-1:0] n);
    logic [DIM_W-1:0] r;
    r = n;
    if (r == '0) r = DIM_W'(1);
    if (r > DIM_W'(DIM_CAP)) r = DIM_W'(DIM_CAP);
    return r;
  endfunction

endpackage

FILE: src/nii_stream_if.sv
// valid/ready channels for requests and results
interface nii_cmd_if;
  import nii_pkg::*;
  logic                    valid;
  logic                    ready;
  logic [1:0]              req_type;
  logic signed [POS_W-1:0] idx_0;
  logic signed [POS_W-1:0] idx_1;
  logic signed [POS_W-1:0] idx_2;
  logic signed [POS_W-1:0] idx_3;

  modport source (output valid, req_type, idx_0, idx_1, idx_2, idx_3, input ready);
  modport sink (input valid, req_type, idx_0, idx_1, idx_2, idx_3, output ready);
endinterface

interface nii_rsp_if;
  import nii_pkg::*;
  logic              valid;
  logic              ready;
  logic [POS_W-1:0]  pos_0;
  logic [POS_W-1:0]  pos_1;
  logic [POS_W-1:0]  pos_2;
  logic [POS_W-1:0]  pos_3;
  logic [FLAT_W-1:0] flat_offset;
  logic              is_out;
  logic [1:0]        load_status;

  modport source (output valid, pos_0, pos_1, pos_2, pos_3, flat_offset, is_out,
                  load_status, input ready);
  modport sink (input valid, pos_0, pos_1, pos_2, pos_3, flat_offset, is_out,
                load_status, output ready);
endinterface

FILE: src/nii_cell.sv
// one dimension: extent, position, carry stage and offset stage
module nii_cell import nii_pkg::*; (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    ext_we,
  input  logic [CFG_W-1:0]        ext_data,
  input  cell_ctrl_t              ctrl,
  input  logic signed [POS_W-1:0] idx,
  input  logic                    carry_in,
  output logic                    carry_out,
  output logic                    out_range,
  output ld_status_e              fail,
  input  flat_t                   flat_in,
  output flat_t                   flat_out,
  output logic [POS_W-1:0]        pos
);

  logic [POS_W-1:0] extent;
  logic [POS_W-1:0] eff;
  logic [POS_W-1:0] pos_inc;
  logic             inc_ok;
  logic [POS_W-1:0] raw;
  logic [POS_W-1:0] mag;
  logic [POS_W-1:0] ld_val;
  logic [POS_W-1:0] pos_next;
  flat_t            flat_next;

  assign eff     = eff_extent(extent);
  assign pos_inc = pos + POS_W'(1);
  assign inc_ok  = pos_inc < eff;

  assign carry_out = ctrl.used ? (carry_in && !inc_ok) : carry_in;
  assign out_range = ctrl.used && (pos >= eff);

  assign raw    = idx;
  assign mag    = (~raw) + POS_W'(1);
  assign ld_val = raw[POS_W-1] ? (eff - mag) : raw;

  always_comb begin
    fail = LD_OK;
    if (ctrl.used) begin
      if (raw[POS_W-1]) begin
        if (mag > eff) fail = LD_NEG_FAR;
      end else if (raw >= eff) begin
        fail = LD_TOO_BIG;
      end
    end
  end

  always_comb begin
    pos_next = pos;
    case (ctrl.req)
      REQ_STEP: begin
        if (ctrl.set_end) begin
          pos_next = ctrl.used ? eff : '0;
        end else if (!ctrl.used) begin
          pos_next = '0;
        end else if (carry_in) begin
          pos_next = inc_ok ? pos_inc : '0;
        end
      end
      REQ_LOAD: begin
        if (ctrl.load_ok) pos_next = ctrl.used ? ld_val : '0;
      end
      REQ_REWIND: pos_next = '0;
      default: pos_next = pos;
    endcase
  end

  // horner step of the row-major offset
  always_comb begin
    flat_next.vld = flat_in.vld;
    flat_next.out = flat_in.out | out_range;
    flat_next.acc = ctrl.used ? (flat_in.acc * FLAT_W'(eff)) + FLAT_W'(pos) : flat_in.acc;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      extent       <= POS_W'(1);
      pos          <= '0;
      flat_out.vld <= 1'b0;
    end else begin
      if (ext_we) extent <= ext_data;
      if (ctrl.apply) pos <= pos_next;
      flat_out <= flat_next;
    end
  end

endmodule

FILE: src/nd_index_iterator.sv
// top level: configuration, cell row, sequencing and result register
//
// Row-major position counter over up to four dimensions, built as a row of
// four cells, one per dimension. An accepted request updates the position at
// its acceptance edge (step carries from the last used cell toward cell 0);
// the flat offset is then formed by a Horner pass that moves through the four
// cells one per cycle. A new request is taken only once the last result has
// reached the output register, since busy holds cmd.ready low until then.
// The result sits in an output register, so the next request is accepted
// while it waits to be taken. Configuration writes take effect at once.
module nd_index_iterator import nii_pkg::*; (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data,
  nii_cmd_if.sink              cmd,
  nii_rsp_if.source            rsp
);

  logic [DIM_W-1:0]                  num_dims;
  logic [DIM_W-1:0]                  n_used;
  logic [NUM_CELLS-1:0]              used;
  logic [NUM_CELLS:0]                carry;
  logic [NUM_CELLS-1:0]              out_range;
  ld_status_e                        fail [NUM_CELLS];
  flat_t                             flat [NUM_CELLS+1];
  logic [NUM_CELLS-1:0][POS_W-1:0]   pos;
  logic signed [POS_W-1:0]           idx [NUM_CELLS];
  cell_ctrl_t                        ctrl [NUM_CELLS];
  logic [NUM_CELLS-1:0]              ext_we;

  logic       busy;
  logic       start;
  logic       apply;
  logic       any_out;
  logic       set_end;
  ld_status_e status;
  ld_status_e status_r;
  res_t       res_now;
  res_t       pend_r;
  logic       pend_vld;
  res_t       out_r;
  logic       out_valid;
  logic       out_free;

  assign n_used    = used_dims(num_dims);
  assign cmd.ready = !busy;
  assign apply     = cmd.valid && cmd.ready;

  assign idx[0] = cmd.idx_0;
  assign idx[1] = cmd.idx_1;
  assign idx[2] = cmd.idx_2;
  assign idx[3] = cmd.idx_3;

  assign carry[NUM_CELLS] = 1'b1;
  assign any_out = |out_range;
  assign set_end = any_out || carry[0];

  assign flat[0].vld = start;
  assign flat[0].out = 1'b0;
  assign flat[0].acc = '0;

  always_comb begin
    status = LD_OK;
    for (int d = NUM_CELLS - 1; d >= 0; d--) begin
      if (fail[d] != LD_OK) status = fail[d];
    end
  end

  for (genvar d = 0; d < NUM_CELLS; d++) begin : g_cell
    assign used[d] = DIM_W'(d) < n_used;
    assign ext_we[d] = cfg_we && (cfg_index == REG_EXTENT_0 + CFG_IDX_W'(d));

    always_comb begin
      ctrl[d].apply   = apply;
      ctrl[d].req     = req_e'(cmd.req_type);
      ctrl[d].used    = used[d];
      ctrl[d].set_end = set_end;
      ctrl[d].load_ok = (status == LD_OK);
    end

    nii_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .ext_we    (ext_we[d]),
      .ext_data  (cfg_data),
      .ctrl      (ctrl[d]),
      .idx       (idx[d]),
      .carry_in  (carry[d+1]),
      .carry_out (carry[d]),
      .out_range (out_range[d]),
      .fail      (fail[d]),
      .flat_in   (flat[d]),
      .flat_out  (flat[d+1]),
      .pos       (pos[d])
    );
  end

  always_comb begin
    for (int d = 0; d < NUM_CELLS; d++) begin
      res_now.pos[d] = used[d] ? pos[d] : '0;
    end
    res_now.flat   = flat[NUM_CELLS].acc;
    res_now.is_out = flat[NUM_CELLS].out;
    res_now.status = status_r;
  end

  assign out_free = !out_valid || rsp.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_dims  <= DIM_W'(1);
      busy      <= 1'b0;
      start     <= 1'b0;
      pend_vld  <= 1'b0;
      out_valid <= 1'b0;
      status_r  <= LD_OK;
    end else begin
      if (cfg_we && cfg_index == REG_NUM_DIMS) num_dims <= cfg_data[DIM_W-1:0];
      start <= apply;
      if (apply) begin
        busy     <= 1'b1;
        status_r <= (req_e'(cmd.req_type) == REQ_LOAD) ? status : LD_OK;
      end
      if (out_free) begin
        if (pend_vld) begin
          out_r     <= pend_r;
          out_valid <= 1'b1;
          pend_vld  <= 1'b0;
          busy      <= 1'b0;
        end else if (flat[NUM_CELLS].vld) begin
          out_r     <= res_now;
          out_valid <= 1'b1;
          busy      <= 1'b0;
        end else begin
          out_valid <= 1'b0;
        end
      end else if (flat[NUM_CELLS].vld) begin
        pend_r   <= res_now;
        pend_vld <= 1'b1;
      end
    end
  end

  assign rsp.valid       = out_valid;
  assign rsp.pos_0       = out_r.pos[0];
  assign rsp.pos_1       = out_r.pos[1];
  assign rsp.pos_2       = out_r.pos[2];
  assign rsp.pos_3       = out_r.pos[3];
  assign rsp.flat_offset = out_r.flat;
  assign rsp.is_out      = out_r.is_out;
  assign rsp.load_status = out_r.status;

endmodule

FILE: tb/tb_nd_index_iterator.sv
// nd_index_iterator testbench: directed table and random requests checked against a predictor
module tb_nd_index_iterator;
  import nii_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] REQ_NONE = 2'd3;
  localparam int STALL_LIMIT = 2000;
  localparam int LONG_HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASES = 16;
  localparam int PHASE_ITEMS = 100;

  typedef enum int {PACE_FULL, PACE_RANDOM, PACE_BURSTY} pace_e;

  typedef struct {
    bit                         is_shape;
    logic [DIM_W-1:0]           nd;
    logic [NUM_CELLS-1:0][POS_W-1:0] ext;
    logic [1:0]                 rq;
    logic [NUM_CELLS-1:0][POS_W-1:0] ix;
    bit                         has_pin;
    res_t                       pin_res;
  } plan_row_t;

  logic clk;
  logic rst;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  nii_cmd_if cmd_ch();
  nii_rsp_if rsp_ch();

  nd_index_iterator u_top (
    .clk(clk),
    .rst(rst),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .cmd(cmd_ch),
    .rsp(rsp_ch)
  );

  logic [DIM_W-1:0] dims_reg;
  logic [POS_W-1:0] ext_reg [NUM_CELLS];
  logic [POS_W-1:0] cur_pos [NUM_CELLS];
  res_t pending_places[$];
  int mismatches = 0;
  int quiet = 0;
  pace_e src_pace = PACE_RANDOM;
  pace_e snk_pace = PACE_RANDOM;
  bit long_hold = 1'b0;
  bit pin_on = 1'b0;
  res_t pin_res;

  always begin
    clk = 1'b0;
    #4;
    clk = 1'b1;
    #4;
  end

  function automatic int unsigned draw_wait(input pace_e pace);
    case (pace)
      PACE_FULL: return 0;
      PACE_RANDOM: return $urandom_range(0, 13);
      default: return ($urandom_range(0, 3) == 0) ? $urandom_range(1, 13) : 0;
    endcase
  endfunction

  function automatic int dims_in_use();
    int n;
    n = dims_reg;
    if (n < 1) n = 1;
    if (n > MAX_DIMS) n = MAX_DIMS;
    if (n > NUM_CELLS) n = NUM_CELLS;
    return n;
  endfunction

  function automatic int ext_of(input int d);
    int e;
    e = ext_reg[d];
    if (e < 1) e = 1;
    if (e > (1 << EXTENT_BITS)) e = 1 << EXTENT_BITS;
    return e;
  endfunction

  function automatic bit beyond_end(input int n);
    for (int d = 0; d < n; d++)
      if (cur_pos[d] >= ext_of(d)) return 1'b1;
    return 1'b0;
  endfunction

  function automatic void park_at_end(input int n);
    for (int d = 0; d < NUM_CELLS; d++)
      cur_pos[d] = (d < n) ? POS_W'(ext_of(d)) : '0;
  endfunction

  function automatic res_t advance_position(input logic [1:0] rq,
                                            input logic [NUM_CELLS-1:0][POS_W-1:0] ix);
    res_t r;
    logic [POS_W-1:0] next [NUM_CELLS];
    int n, d, e, v, mag;
    bit carry;
    longint unsigned stride, flat;
    n = dims_in_use();
    r.status = LD_OK;
    case (rq)
      REQ_STEP: begin
        if (beyond_end(n)) begin
          park_at_end(n);
        end else begin
          for (d = n; d < NUM_CELLS; d++) cur_pos[d] = '0;
          carry = 1'b1;
          for (d = n - 1; d >= 0 && carry; d--) begin
            v = cur_pos[d] + 1;
            if (v < ext_of(d)) begin
              cur_pos[d] = POS_W'(v);
              carry = 1'b0;
            end else begin
              cur_pos[d] = '0;
            end
          end
          if (carry) park_at_end(n);
        end
      end
      REQ_LOAD: begin
        for (d = 0; d < NUM_CELLS; d++) next[d] = '0;
        for (d = 0; d < n && r.status == LD_OK; d++) begin
          e = ext_of(d);
          if (ix[d][POS_W-1]) begin
            mag = (1 << POS_W) - int'(ix[d]);
            if (mag > e) r.status = LD_NEG_FAR;
            else next[d] = POS_W'(e - mag);
          end else if (int'(ix[d]) >= e) begin
            r.status = LD_TOO_BIG;
          end else begin
            next[d] = ix[d];
          end
        end
        if (r.status == LD_OK)
          for (d = 0; d < NUM_CELLS; d++) cur_pos[d] = next[d];
      end
      REQ_REWIND: begin
        for (d = 0; d < NUM_CELLS; d++) cur_pos[d] = '0;
      end
      default: ;
    endcase
    flat = 0;
    stride = 1;
    for (d = 0; d < NUM_CELLS; d++) r.pos[d] = (d < n) ? cur_pos[d] : '0;
    for (d = n - 1; d >= 0; d--) begin
      flat += longint'(cur_pos[d]) * stride;
      stride *= longint'(ext_of(d));
    end
    r.flat = FLAT_W'(flat);
    r.is_out = beyond_end(n);
    return r;
  endfunction

  task automatic note_mismatch(input string field, input longint unsigned got,
                               input longint unsigned want);
    mismatches++;
    $display("%0t mismatch on %s: got 0x%0h want 0x%0h", $time, field, got, want);
  endtask

  always @(posedge clk) begin : track
    res_t got;
    res_t want;
    if (rst) begin
      dims_reg = DIM_W'(1);
      for (int d = 0; d < NUM_CELLS; d++) begin
        ext_reg[d] = POS_W'(1);
        cur_pos[d] = '0;
      end
      pending_places.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_NUM_DIMS)
          dims_reg = cfg_data[DIM_W-1:0];
        else if (cfg_index >= REG_EXTENT_0 && cfg_index < REG_EXTENT_0 + NUM_CELLS)
          ext_reg[cfg_index - REG_EXTENT_0] = cfg_data;
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        want = advance_position(cmd_ch.req_type,
                                {cmd_ch.idx_3, cmd_ch.idx_2, cmd_ch.idx_1, cmd_ch.idx_0});
        pending_places.push_back(pin_on ? pin_res : want);
      end
      if (rsp_ch.valid && rsp_ch.ready) begin
        got.pos = {rsp_ch.pos_3, rsp_ch.pos_2, rsp_ch.pos_1, rsp_ch.pos_0};
        got.flat = rsp_ch.flat_offset;
        got.is_out = rsp_ch.is_out;
        got.status = ld_status_e'(rsp_ch.load_status);
        if (pending_places.size() == 0) begin
          note_mismatch("item with none expected", got.flat, 0);
        end else begin
          want = pending_places.pop_front();
          for (int d = 0; d < NUM_CELLS; d++)
            if (got.pos[d] !== want.pos[d])
              note_mismatch($sformatf("pos_%0d", d), got.pos[d], want.pos[d]);
          if (got.flat !== want.flat) note_mismatch("flat_offset", got.flat, want.flat);
          if (got.is_out !== want.is_out) note_mismatch("is_out", got.is_out, want.is_out);
          if (got.status !== want.status) note_mismatch("load_status", got.status, want.status);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet <= 0;
    end else if (quiet >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin : result_taker
    int unsigned stall;
    rsp_ch.ready = 1'b0;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      stall = draw_wait(snk_pace);
      if (long_hold) begin
        stall = LONG_HOLD_CYCLES;
        long_hold = 1'b0;
      end
      if (stall > 0) begin
        rsp_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      rsp_ch.ready <= 1'b1;
      @(posedge clk);
      while (!rsp_ch.valid) @(posedge clk);
      @(negedge clk);
    end
  end

  task automatic offer(input logic [1:0] rq, input logic [NUM_CELLS-1:0][POS_W-1:0] ix,
                       input bit pin, input res_t pinned);
    int unsigned gap;
    gap = draw_wait(src_pace);
    if (gap > 0) begin
      cmd_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    pin_on = pin;
    pin_res = pinned;
    cmd_ch.valid <= 1'b1;
    cmd_ch.req_type <= rq;
    cmd_ch.idx_0 <= ix[0];
    cmd_ch.idx_1 <= ix[1];
    cmd_ch.idx_2 <= ix[2];
    cmd_ch.idx_3 <= ix[3];
    @(posedge clk);
    while (!cmd_ch.ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    cmd_ch.valid <= 1'b0;
    while (pending_places.size() != 0) @(negedge clk);
  endtask

  task automatic apply_shape(input logic [DIM_W-1:0] nd,
                             input logic [NUM_CELLS-1:0][POS_W-1:0] ext);
    cfg_we <= 1'b1;
    cfg_index <= REG_NUM_DIMS;
    cfg_data <= CFG_W'(nd);
    @(negedge clk);
    for (int d = 0; d < NUM_CELLS; d++) begin
      cfg_index <= REG_EXTENT_0 + CFG_IDX_W'(d);
      cfg_data <= ext[d];
      @(negedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  function automatic plan_row_t shape_row(input int nd, input int e0, input int e1,
                                          input int e2, input int e3);
    plan_row_t r;
    r.is_shape = 1'b1;
    r.nd = DIM_W'(nd);
    r.ext = {POS_W'(e3), POS_W'(e2), POS_W'(e1), POS_W'(e0)};
    r.has_pin = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t req_row(input logic [1:0] rq, input int i0, input int i1,
                                        input int i2, input int i3);
    plan_row_t r;
    r.is_shape = 1'b0;
    r.rq = rq;
    r.ix = {POS_W'(i3), POS_W'(i2), POS_W'(i1), POS_W'(i0)};
    r.has_pin = 1'b0;
    return r;
  endfunction

  function automatic plan_row_t pin_result(input plan_row_t r, input int p0, input int p1,
                                           input int p2, input int p3,
                                           input longint unsigned flat, input bit is_out,
                                           input ld_status_e st);
    r.has_pin = 1'b1;
    r.pin_res.pos = {POS_W'(p3), POS_W'(p2), POS_W'(p1), POS_W'(p0)};
    r.pin_res.flat = FLAT_W'(flat);
    r.pin_res.is_out = is_out;
    r.pin_res.status = st;
    return r;
  endfunction

  initial begin : stimulus
    plan_row_t plan[$];
    logic [1:0] rq;
    logic [NUM_CELLS-1:0][POS_W-1:0] ix;
    logic [NUM_CELLS-1:0][POS_W-1:0] ext;
    logic [DIM_W-1:0] nd;
    int n, e, v, pick;
    rst = 1'b1;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    cmd_ch.valid = 1'b0;
    cmd_ch.req_type = '0;
    cmd_ch.idx_0 = '0;
    cmd_ch.idx_1 = '0;
    cmd_ch.idx_2 = '0;
    cmd_ch.idx_3 = '0;

    // after reset: one dimension of extent one
    plan.push_back(pin_result(req_row(REQ_REWIND, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, LD_OK));
    plan.push_back(pin_result(req_row(REQ_STEP, 0, 0, 0, 0), 1, 0, 0, 0, 1, 1, LD_OK));
    plan.push_back(pin_result(req_row(REQ_STEP, 5, 5, 5, 5), 1, 0, 0, 0, 1, 1, LD_OK));
    plan.push_back(pin_result(req_row(REQ_NONE, -1, -1, -1, -1), 1, 0, 0, 0, 1, 1, LD_OK));
    plan.push_back(pin_result(req_row(REQ_LOAD, 0, 0, 0, 0), 0, 0, 0, 0, 0, 0, LD_OK));
    plan.push_back(pin_result(req_row(REQ_LOAD, -1, 4095, -4096, 1), 0, 0, 0, 0, 0, 0,
                              LD_OK));
    plan.push_back(pin_result(req_row(REQ_LOAD, -2, 0, 0, 0), 0, 0, 0, 0, 0, 0, LD_NEG_FAR));
    plan.push_back(pin_result(req_row(REQ_LOAD, 1, 0, 0, 0), 0, 0, 0, 0, 0, 0, LD_TOO_BIG));
    // full size in every dimension
    plan.push_back(shape_row(4, 4096, 4096, 4096, 4096));
    plan.push_back(pin_result(req_row(REQ_LOAD, 4095, 4095, 4095, 4095),
                              4095, 4095, 4095, 4095, 64'hFFFF_FFFF_FFFF, 0, LD_OK));
    plan.push_back(pin_result(req_row(REQ_STEP, 0, 0, 0, 0), 4096, 4096, 4096, 4096,
                              64'h1_0010_0100_1000, 1, LD_OK));
    plan.push_back(pin_result(req_row(REQ_STEP, 0, 0, 0, 0), 4096, 4096, 4096, 4096,
                              64'h1_0010_0100_1000, 1, LD_OK));
    plan.push_back(pin_result(req_row(REQ_LOAD, -4096, -4096, -4096, -4096), 0, 0, 0, 0, 0, 0,
                              LD_OK));
    plan.push_back(req_row(REQ_LOAD, 4095, 4095, 4095, 4094));
    plan.push_back(req_row(REQ_STEP, 0, 0, 0, 0));
    plan.push_back(req_row(REQ_STEP, 0, 0, 0, 0));
    // dimension count and extents beyond their ranges
    plan.push_back(shape_row(7, 0, 8191, 3, 2));
    plan.push_back(req_row(REQ_LOAD, 0, -4096, -3, -2));
    plan.push_back(pin_result(req_row(REQ_LOAD, 0, 1, 3, -3), 0, 0, 0, 0, 0, 0, LD_TOO_BIG));
    plan.push_back(pin_result(req_row(REQ_LOAD, 0, 4095, -4, 5), 0, 0, 0, 0, 0, 0,
                              LD_NEG_FAR));
    plan.push_back(req_row(REQ_LOAD, 0, 4095, 2, 1));
    plan.push_back(req_row(REQ_STEP, 0, 0, 0, 0));
    // shrink while at the end marker
    plan.push_back(shape_row(2, 5, 7, 1, 1));
    plan.push_back(req_row(REQ_NONE, 0, 0, 0, 0));
    plan.push_back(req_row(REQ_STEP, 0, 0, 0, 0));
    plan.push_back(req_row(REQ_REWIND, 0, 0, 0, 0));
    plan.push_back(req_row(REQ_STEP, 0, 0, 0, 0));
    plan.push_back(shape_row(0, 4096, 2, 2, 2));
    plan.push_back(req_row(REQ_LOAD, -1, 1, 1, 1));
    plan.push_back(req_row(REQ_STEP, 0, 0, 0, 0));

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (plan[i]) begin
      if (plan[i].is_shape) begin
        drain();
        apply_shape(plan[i].nd, plan[i].ext);
      end else begin
        offer(plan[i].rq, plan[i].ix, plan[i].has_pin, plan[i].pin_res);
      end
    end

    for (int p = 0; p < PHASES; p++) begin
      drain();
      nd = ($urandom_range(0, 9) == 0) ? DIM_W'($urandom_range(0, 7))
                                        : DIM_W'($urandom_range(1, 4));
      for (int d = 0; d < NUM_CELLS; d++) begin
        case ($urandom_range(0, 11))
          0: ext[d] = '0;
          1: ext[d] = POS_W'(4096);
          2: ext[d] = POS_W'(4095);
          3: ext[d] = POS_W'($urandom);
          default: ext[d] = POS_W'($urandom_range(1, 6));
        endcase
      end
      if (p == 0) begin
        nd = DIM_W'(4);
        ext = {NUM_CELLS{POS_W'(4096)}};
      end else if (p == 1) begin
        nd = DIM_W'(1);
        ext = {NUM_CELLS{POS_W'(1)}};
      end
      apply_shape(nd, ext);
      src_pace = pace_e'($urandom_range(0, 2));
      snk_pace = pace_e'($urandom_range(0, 2));
      if (p == 3) begin
        src_pace = PACE_FULL;
        long_hold = 1'b1;
      end
      n = dims_in_use();
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        for (int d = 0; d < NUM_CELLS; d++) ix[d] = POS_W'($urandom);
        pick = $urandom_range(0, 99);
        if (pick < 60) begin
          rq = REQ_STEP;
        end else if (pick < 80) begin
          rq = REQ_LOAD;
          for (int d = 0; d < n; d++) begin
            e = ext_of(d);
            case ($urandom_range(0, 4))
              0: v = e - 1;
              1: v = -1;
              2: v = -e;
              3: v = 0;
              default: v = int'($urandom_range(0, 2 * e - 1)) - e;
            endcase
            ix[d] = POS_W'(v);
          end
        end else if (pick < 88) begin
          rq = REQ_LOAD;
        end else if (pick < 95) begin
          rq = REQ_REWIND;
        end else begin
          rq = REQ_NONE;
        end
        offer(rq, ix, 1'b0, '0);
      end
    end

    drain();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule
